// ----- hdl/swa_pkg.sv -----
// Shared constants for the sliding window average block.
// No dependencies; imported by the front end, the divider, the top level and the testbench.
package swa_pkg;

   // Window length register
   localparam int          WLEN_W     = 11;
   localparam logic [10:0] WLEN_RESET = 11'd4;

   // Defaults for the top-level parameters
   localparam int DEF_MAX_WINDOW   = 1024;
   localparam int DEF_SAMPLE_WIDTH = 32;

endpackage

// ----- hdl/swa_front.sv -----
// Front end: accepts sample beats, keeps the sample ring, count and running sum,
// and issues one divide job per average. Depends on swa_pkg.
module swa_front
   import swa_pkg::*;
#(
   parameter int MAX_WINDOW   = DEF_MAX_WINDOW,
   parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
   localparam int SUM_W = SAMPLE_WIDTH + WLEN_W,
   localparam int JOB_W = SUM_W + WLEN_W + 1,
   localparam int PTR_W = $clog2(MAX_WINDOW)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wen,
   input  logic [WLEN_W-1:0]       csr_wdata,
   input  logic                    smp_valid,
   output logic                    smp_ready,
   input  logic [SAMPLE_WIDTH-1:0] smp_data,
   input  logic                    smp_last,
   output logic                    job_valid,
   input  logic                    job_ready,
   output logic [JOB_W-1:0]        job_data   // {last, divisor, sum}
);

   typedef enum logic {ST_IDLE, ST_UPDATE} state_type;

   state_type               state_ff;
   logic [WLEN_W-1:0]       wlen_ff;
   logic [WLEN_W-1:0]       win_ff;
   logic [SAMPLE_WIDTH-1:0] smp_ff;
   logic                    eos_ff;
   logic [SUM_W-1:0]        sum_ff;
   logic [WLEN_W-1:0]       cnt_ff;
   logic [PTR_W-1:0]        ptr_ff;

   logic [SAMPLE_WIDTH-1:0] ring_mem [MAX_WINDOW];
   logic [SAMPLE_WIDTH-1:0] ring_rd_ff;

   logic                    accept;
   logic [WLEN_W-1:0]       win_eff;
   logic [PTR_W-1:0]        ptr_norm;
   logic [WLEN_W-1:0]       cnt_norm;
   logic                    fill;
   logic [SUM_W-1:0]        sum_in;
   logic [WLEN_W-1:0]       cnt_in;
   logic [PTR_W-1:0]        ptr_in;
   logic                    emit;

   // Ready only when the queue can take whatever job this beat produces.
   assign smp_ready = (state_ff == ST_IDLE) && job_ready;
   assign accept    = smp_valid && smp_ready;

   assign win_eff  = (32'(wlen_ff) > MAX_WINDOW) ? WLEN_W'(MAX_WINDOW) : wlen_ff;
   assign ptr_norm = (32'(ptr_ff) >= 32'(win_eff)) ? '0 : ptr_ff;
   assign cnt_norm = (cnt_ff > win_eff) ? win_eff : cnt_ff;

   assign fill   = cnt_ff < win_ff;
   assign sum_in = fill
                   ? sum_ff + {{WLEN_W{smp_ff[SAMPLE_WIDTH-1]}}, smp_ff}
                   : sum_ff - {{WLEN_W{ring_rd_ff[SAMPLE_WIDTH-1]}}, ring_rd_ff}
                            + {{WLEN_W{smp_ff[SAMPLE_WIDTH-1]}}, smp_ff};
   assign cnt_in = fill ? cnt_ff + 1'b1 : cnt_ff;
   assign ptr_in = (32'(ptr_ff) + 1 == 32'(win_ff)) ? '0 : ptr_ff + 1'b1;
   assign emit   = (cnt_in == win_ff) || eos_ff;

   assign job_valid = (state_ff == ST_UPDATE) && emit;
   assign job_data  = {eos_ff, cnt_in, sum_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wlen_ff  <= WLEN_RESET;
         sum_ff   <= '0;
         cnt_ff   <= '0;
         ptr_ff   <= '0;
      end else begin
         if (csr_wen) begin
            wlen_ff <= csr_wdata;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (win_eff == '0) begin
                     // disabled window: drop the beat, still honor end of series
                     if (smp_last) begin
                        sum_ff <= '0;
                        cnt_ff <= '0;
                        ptr_ff <= '0;
                     end
                  end else begin
                     ptr_ff   <= ptr_norm;
                     cnt_ff   <= cnt_norm;
                     win_ff   <= win_eff;
                     smp_ff   <= smp_data;
                     eos_ff   <= smp_last;
                     state_ff <= ST_UPDATE;
                  end
               end
            end
            ST_UPDATE: begin
               if (eos_ff) begin
                  sum_ff <= '0;
                  cnt_ff <= '0;
                  ptr_ff <= '0;
               end else begin
                  sum_ff <= sum_in;
                  cnt_ff <= cnt_in;
                  ptr_ff <= ptr_in;
               end
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Ring: read the oldest entry on accept, overwrite it in the update cycle.
   always_ff @(posedge clock) begin
      if (state_ff == ST_UPDATE) begin
         ring_mem[ptr_ff] <= smp_ff;
      end
      if (accept) begin
         ring_rd_ff <= ring_mem[ptr_norm];
      end
   end

endmodule

// ----- hdl/swa_queue.sv -----
// Two-entry job queue between the front end and the divider.
// No dependencies.
module swa_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       fill_ff;
   logic             do_push;
   logic             do_pop;

   assign push_ready = fill_ff != 2'd2;
   assign pop_valid  = fill_ff != 2'd0;
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (do_push && !do_pop) begin
            fill_ff <= fill_ff + 2'd1;
         end else if (do_pop && !do_push) begin
            fill_ff <= fill_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hdl/swa_divider.sv -----
// Back end: bit-serial signed divide of the running sum by the divisor,
// saturation to the sample range and the result output register. Depends on swa_pkg.
module swa_divider
   import swa_pkg::*;
#(
   parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
   localparam int SUM_W = SAMPLE_WIDTH + WLEN_W,
   localparam int JOB_W = SUM_W + WLEN_W + 1,
   localparam int CNT_W = $clog2(SUM_W)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    job_valid,
   output logic                    job_ready,
   input  logic [JOB_W-1:0]        job_data,    // {last, divisor, sum}
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [SAMPLE_WIDTH-1:0] out_average,
   output logic [WLEN_W-1:0]       out_divisor,
   output logic                    out_last
);

   typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_DONE} state_type;

   state_type               state_ff;
   logic [SUM_W-1:0]        quo_ff;
   logic [WLEN_W-1:0]       rem_ff;
   logic [WLEN_W-1:0]       div_ff;
   logic                    neg_ff;
   logic                    last_ff;
   logic [CNT_W-1:0]        step_ff;
   logic                    out_valid_ff;
   logic [SAMPLE_WIDTH-1:0] out_average_ff;
   logic [WLEN_W-1:0]       out_divisor_ff;
   logic                    out_last_ff;

   logic [SUM_W-1:0]        job_sum;
   logic [SUM_W-1:0]        job_mag;
   logic [WLEN_W:0]         trial;
   logic [WLEN_W:0]         diff;
   logic                    pos_big;
   logic                    neg_big;
   logic [SAMPLE_WIDTH-1:0] neg_quo;
   logic [SAMPLE_WIDTH-1:0] avg_sat;
   logic                    out_free;

   assign job_sum = job_data[SUM_W-1:0];
   assign job_mag = job_sum[SUM_W-1] ? (~job_sum + 1'b1) : job_sum;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   assign trial = {rem_ff, quo_ff[SUM_W-1]};
   assign diff  = trial - {1'b0, div_ff};

   assign pos_big = |quo_ff[SUM_W-1:SAMPLE_WIDTH-1];
   assign neg_big = (|quo_ff[SUM_W-1:SAMPLE_WIDTH])
                    || (quo_ff[SAMPLE_WIDTH-1] && (|quo_ff[SAMPLE_WIDTH-2:0]));
   assign neg_quo = ~quo_ff[SAMPLE_WIDTH-1:0] + SAMPLE_WIDTH'(1);
   assign avg_sat = neg_ff
                    ? (neg_big ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}} : neg_quo)
                    : (pos_big ? {1'b0, {(SAMPLE_WIDTH-1){1'b1}}}
                               : quo_ff[SAMPLE_WIDTH-1:0]);

   assign out_free  = !out_valid_ff || out_ready;
   assign job_ready = (state_ff == ST_IDLE);

   assign out_valid   = out_valid_ff;
   assign out_average = out_average_ff;
   assign out_divisor = out_divisor_ff;
   assign out_last    = out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         // drop the beat once taken, unless the done state reloads it
         if (out_valid_ff && out_ready && (state_ff != ST_DONE)) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (job_valid) begin
                  quo_ff   <= job_mag;
                  neg_ff   <= job_sum[SUM_W-1];
                  rem_ff   <= '0;
                  div_ff   <= job_data[SUM_W +: WLEN_W];
                  last_ff  <= job_data[JOB_W-1];
                  step_ff  <= '0;
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (!diff[WLEN_W]) begin
                  rem_ff <= diff[WLEN_W-1:0];
                  quo_ff <= {quo_ff[SUM_W-2:0], 1'b1};
               end else begin
                  rem_ff <= trial[WLEN_W-1:0];
                  quo_ff <= {quo_ff[SUM_W-2:0], 1'b0};
               end
               step_ff <= step_ff + 1'b1;
               if (32'(step_ff) == SUM_W - 1) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               // hold the quotient until the output register frees up
               if (out_free) begin
                  out_valid_ff   <= 1'b1;
                  out_average_ff <= avg_sat;
                  out_divisor_ff <= div_ff;
                  out_last_ff    <= last_ff;
                  state_ff       <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// ----- hdl/sliding_window_average.sv -----
// Boxcar moving average over a stream of signed fixed-point samples.
// The front end handles each beat as a ring read, then an update, and takes no new beat until
// it is back in idle with the queue ready; the bit-serial divider takes a new job only when
// idle, once the last quotient bit is done and the result has moved to the output register.
// Reset is synchronous: window length returns to 4, sum, count and pointer clear,
// queue and output empty; the sample ring is not cleared.
module sliding_window_average
   import swa_pkg::*;
#(
   parameter int MAX_WINDOW   = DEF_MAX_WINDOW,
   parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
   localparam int SUM_W = SAMPLE_WIDTH + WLEN_W,
   localparam int JOB_W = SUM_W + WLEN_W + 1,
   localparam int IN_W  = ((SAMPLE_WIDTH + 7) / 8) * 8,
   localparam int OUT_W = ((SAMPLE_WIDTH + WLEN_W + 7) / 8) * 8
) (
   input  logic              clock,
   input  logic              reset,
   // window length register
   input  logic              csr_wen,
   input  logic [WLEN_W-1:0] csr_wdata,
   // sample beats
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [IN_W-1:0]   req_tdata,    // sample, then zero pad
   input  logic              req_tlast,    // end_of_series
   // average beats
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [OUT_W-1:0]  rsp_tdata,    // average, divisor_used, then zero pad
   output logic              rsp_tlast     // last_of_series
);

   logic                    fq_valid;
   logic                    fq_ready;
   logic [JOB_W-1:0]        fq_data;
   logic                    qd_valid;
   logic                    qd_ready;
   logic [JOB_W-1:0]        qd_data;
   logic [SAMPLE_WIDTH-1:0] average;
   logic [WLEN_W-1:0]       divisor_used;

   // Front end: ring, count and running sum; one job per average to emit.
   swa_front #(
      .MAX_WINDOW   (MAX_WINDOW),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata),
      .smp_valid (req_tvalid),
      .smp_ready (req_tready),
      .smp_data  (req_tdata[SAMPLE_WIDTH-1:0]),
      .smp_last  (req_tlast),
      .job_valid (fq_valid),
      .job_ready (fq_ready),
      .job_data  (fq_data)
   );

   // Short queue: lets the front end keep taking beats while a divide runs.
   swa_queue #(
      .WIDTH (JOB_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_data  (fq_data),
      .pop_valid  (qd_valid),
      .pop_ready  (qd_ready),
      .pop_data   (qd_data)
   );

   // Back end: divide, saturate, hold the result in the output register.
   swa_divider #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_divider (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (qd_valid),
      .job_ready   (qd_ready),
      .job_data    (qd_data),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_average (average),
      .out_divisor (divisor_used),
      .out_last    (rsp_tlast)
   );

   // Pack the result beat, first field in the low bits.
   assign rsp_tdata = OUT_W'({divisor_used, average});

endmodule

// ----- tb/sliding_window_average_tb.sv -----
// Self-checking testbench for the sliding window average block.
// Depends on swa_pkg and sliding_window_average; drives sample beats and window writes,
// and checks every average beat against a built-in scoreboard.
module sliding_window_average_tb
   import swa_pkg::*;
();

   // Margin to wait when idling, so that beats still in flight can come out.
   localparam int DRAIN_CYCLES = 80;
   // No beat accepted on either side for this many cycles means a hang.
   localparam int IDLE_LIMIT   = 4000;
   localparam int N_PHASES     = 17;

   localparam longint AVG_MAX = 64'sd2147483647;
   localparam longint AVG_MIN = -64'sd2147483648;

   typedef struct packed {
      logic [31:0]       average;
      logic [WLEN_W-1:0] divisor;
      logic              last;
   } avg_beat_type;

   typedef enum {FILL_RANDOM, FILL_MAX, FILL_MIN} fill_mode_type;
   typedef enum {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PERIODIC} ready_mode_type;

   // Window length as the block applies it: anything above the ring depth acts as the depth.
   function automatic int unsigned clamp_window(input int unsigned w);
      return (w > DEF_MAX_WINDOW) ? DEF_MAX_WINDOW : w;
   endfunction

   // Scoreboard: a running copy of the ring, sum, count and pointer, and a queue of
   // the averages those samples must produce.
   class avg_scoreboard_type;
      logic [31:0]        ring [DEF_MAX_WINDOW];
      logic signed [42:0] sum;
      int unsigned        count;
      int unsigned        ptr;
      int unsigned        window;
      avg_beat_type       expected_q [$];
      int                 errors;
      int                 samples_noted;
      int                 averages_checked;
      int                 series_closed;

      function new();
         foreach (ring[i]) ring[i] = '0;
         window = 32'(WLEN_RESET);
         clear_series();
      endfunction

      function void clear_series();
         sum   = '0;
         count = 0;
         ptr   = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Advance the model by one accepted sample beat.
      function void note_sample(input logic [31:0] smp, input logic last);
         int unsigned  w;
         longint       q;
         avg_beat_type r;
         samples_noted++;
         w = clamp_window(window);
         if (w == 0) begin
            // Disabled window: drop the sample, but end of series still clears.
            if (last) clear_series();
            return;
         end
         // A window lowered mid-series pulls the pointer and count back inside it.
         if (ptr >= w) ptr = 0;
         if (count > w) count = w;
         if (count < w) begin
            ring[ptr] = smp;
            sum = sum + 43'($signed(smp));
            count++;
         end else begin
            sum = sum - 43'($signed(ring[ptr])) + 43'($signed(smp));
            ring[ptr] = smp;
         end
         ptr = (ptr + 1) % w;
         if (count == w || last) begin
            // Signed division truncates toward zero; saturate to the sample range.
            q = longint'(sum) / longint'(count);
            if (q > AVG_MAX) q = AVG_MAX;
            if (q < AVG_MIN) q = AVG_MIN;
            r.average = q[31:0];
            r.divisor = count[WLEN_W-1:0];
            r.last    = last;
            expected_q = {expected_q, r};
         end
         if (last) clear_series();
      endfunction

      // Compare one accepted average beat with the oldest expectation.
      function void check_result(input logic [31:0] avg, input logic [WLEN_W-1:0] div,
                                 input logic last);
         avg_beat_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected average beat, expected none actual %h/%0d/%b",
                     $time, avg, div, last);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         averages_checked++;
         if (want.last) series_closed++;
         if (avg !== want.average) begin
            $display("%0t: average mismatch, expected %h actual %h", $time, want.average, avg);
            errors++;
         end
         if (div !== want.divisor) begin
            $display("%0t: divisor mismatch, expected %0d actual %0d", $time, want.divisor, div);
            errors++;
         end
         if (last !== want.last) begin
            $display("%0t: last_of_series mismatch, expected %b actual %b",
                     $time, want.last, last);
            errors++;
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              csr_wen;
   logic [WLEN_W-1:0] csr_wdata;
   logic              req_tvalid;
   logic              req_tready;
   logic [31:0]       req_tdata;    // sample
   logic              req_tlast;    // end_of_series
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [47:0]       rsp_tdata;    // average, divisor_used, zero pad
   logic              rsp_tlast;    // last_of_series

   avg_scoreboard_type sb = new();

   int burst_left;
   int windows_set;
   int idle_cycles;

   // Phase plan: window setting, beat count, sample fill, forced series length
   // (0 picks random lengths) and whether to close the series at the end of the phase.
   int unsigned   phase_win   [N_PHASES] = '{4, 1, 2, 2047, 1024, 8, 2, 0, 12, 5, 2,
                                              0, 0, 0, 0, 0, 0};
   int            phase_items [N_PHASES] = '{40, 40, 40, 1030, 40, 12, 10, 30, 60, 8, 20,
                                              40, 40, 40, 40, 40, 40};
   fill_mode_type phase_fill  [N_PHASES] = '{FILL_RANDOM, FILL_RANDOM, FILL_RANDOM,
                                              FILL_RANDOM, FILL_RANDOM, FILL_MAX, FILL_MAX,
                                              FILL_RANDOM, FILL_RANDOM, FILL_MIN, FILL_RANDOM,
                                              FILL_RANDOM, FILL_RANDOM, FILL_RANDOM,
                                              FILL_RANDOM, FILL_RANDOM, FILL_RANDOM};
   int            phase_fixed [N_PHASES] = '{0, 0, 0, 1030, 0, 100, 100, 0, 0, 100, 0,
                                              0, 0, 0, 0, 0, 0};
   bit            phase_close [N_PHASES] = '{0, 0, 0, 0, 1, 0, 0, 0, 1, 0, 0,
                                              0, 0, 0, 0, 0, 0};

   // Directed opening at the reset window of 4: extremes, a one-sample series, short
   // series, a full window that slides, and truncation toward zero of negative sums.
   logic [31:0] dir_smp  [23] = '{32'h7fffffff,
                                  32'h80000000, 32'h80000000, 32'h80000000,
                                  32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                  32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                                  32'hffffffff, 32'hffffffff, 32'hfffffffe,
                                  32'h00000000, 32'h00000001,
                                  32'h00000005, 32'h00000000, 32'h00000000, 32'h00000000,
                                  32'hfffffffb, 32'h00000000};
   bit          dir_last [23] = '{1, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 1, 0, 1,
                                  0, 0, 0, 0, 0, 1};

   sliding_window_average dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Random series length for a window: short for big windows, past the fill for small.
   function automatic int series_length(input int unsigned eff);
      if (eff == 0) return $urandom_range(1, 8);
      if (eff > 64) return $urandom_range(1, 40);
      return $urandom_range(1, 2 * eff + 4);
   endfunction

   // Drop valid and hold the sender off for a number of cycles.
   task automatic park_sender(input int cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // Hold the sender until every expected average has come out.
   task automatic drain_results();
      park_sender(1);
      while (sb.pending() != 0) @(negedge clock);
   endtask

   // Present one sample beat, in bursts with random gaps, and wait for the handshake.
   task automatic feed_sample(input logic [31:0] smp, input logic last);
      if (burst_left == 0) begin
         park_sender($urandom_range(1, 6));
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= smp;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      sb.note_sample(smp, last);
      @(negedge clock);
   endtask

   // Write the window register once the block has gone quiet.
   task automatic write_window(input int unsigned w);
      drain_results();
      // Beats that produce no average may still be in flight; let them settle.
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= w[WLEN_W-1:0];
      @(negedge clock);
      csr_wen   <= 1'b0;
      sb.window = w;
      windows_set++;
   endtask

   // Receiver: switch among always ready, coin toss, sparse and periodic stalls.
   ready_mode_type ready_mode;
   int             ready_left;
   initial begin
      rsp_tready = 1'b0;
      ready_mode = READY_ALWAYS;
      ready_left = 0;
   end
   always @(negedge clock) begin
      if (ready_left == 0) begin
         ready_mode = ready_mode_type'($urandom_range(0, 3));
         ready_left = $urandom_range(16, 160);
      end
      ready_left--;
      case (ready_mode)
         READY_ALWAYS:   rsp_tready <= 1'b1;
         READY_COIN:     rsp_tready <= 1'($urandom_range(0, 1));
         READY_SPARSE:   rsp_tready <= ($urandom_range(0, 7) == 0);
         default:        rsp_tready <= ((ready_left % 24) < 6);
      endcase
   end

   // Check every average beat accepted at a rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata[31:0], rsp_tdata[42:32], rsp_tlast);
   end

   // Watchdog: end the run if neither side moves a beat for too long.
   initial begin
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
   end

   // Main stimulus.
   initial begin
      int unsigned eff;
      int          series_left;
      logic [31:0] smp;
      logic        last;

      reset       = 1'b1;
      csr_wen     = 1'b0;
      csr_wdata   = '0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      burst_left  = 0;
      windows_set = 0;

      // Random windows for the tail phases.
      for (int p = 11; p < N_PHASES; p++) phase_win[p] = $urandom_range(1, 20);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_smp[i]) feed_sample(dir_smp[i], dir_last[i]);

      for (int p = 0; p < N_PHASES; p++) begin
         // Phase 0 runs at the reset window; every later phase writes its own.
         if (p != 0) write_window(phase_win[p]);
         eff = clamp_window(phase_win[p]);
         series_left = (phase_fixed[p] != 0) ? phase_fixed[p] : series_length(eff);
         for (int i = 0; i < phase_items[p]; i++) begin
            case (phase_fill[p])
               FILL_MAX: smp = 32'h7fffffff;
               FILL_MIN: smp = 32'h80000000;
               default: begin
                  case ($urandom_range(0, 15))
                     0:       smp = 32'h7fffffff;
                     1:       smp = 32'h80000000;
                     2:       smp = $urandom_range(0, 15) - 8;
                     default: smp = $urandom;
                  endcase
               end
            endcase
            series_left--;
            last = (series_left == 0);
            // Close the series before a larger window so no slide reads a stale slot.
            if (i == phase_items[p] - 1 && p < N_PHASES - 1 &&
                (phase_close[p] || clamp_window(phase_win[p + 1]) > eff))
               last = 1'b1;
            if (last) series_left = series_length(eff);
            if ($urandom_range(0, 299) == 0) drain_results();
            feed_sample(smp, last);
         end
      end

      // Wind down: release the bus, wait out every expected average, then idle.
      drain_results();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Run fed %0d samples through %0d window writes (0, 1, 1024, above 1024).",
               sb.samples_noted, windows_set);
      $display("Checked %0d averages, %0d of them closing a series.",
               sb.averages_checked, sb.series_closed);
      if (sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
